/* design/mandelbrot_escape_time_pixel_defines.svh */
// Assertion macros shared by the Mandelbrot pixel engine modules.
// Depends on nothing; expects signals named clk and arst_n in the including module.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MET_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/met_pkg.sv */
// Shared types and constants for the Mandelbrot escape-time pixel engine.
// Used by every module of the block; depends on nothing.
package met_pkg;

	// Fixed-point format of the complex plane: signed Q4.FRAC_BITS.
	localparam int FRAC_BITS  = 28;
	localparam int COORD_BITS = 12;
	localparam int XW         = FRAC_BITS + 4;
	localparam int PW         = 2 * XW;
	// |z|^2 >= 4 means the exact square sum reaches 2^(2F+2).
	localparam int ESC_BIT    = 2 * FRAC_BITS + 2;

	localparam int MAX_ITER_W = 10;
	localparam int COUNT_W    = MAX_ITER_W + 1;
	localparam int STEP_W     = FRAC_BITS + 1;
	localparam int COLOR_W    = 8;

	// Register reset values.
	localparam logic [MAX_ITER_W-1:0] RST_MAX_ITER   = MAX_ITER_W'(500);
	localparam logic [COORD_BITS-1:0] RST_CENTER_COL = COORD_BITS'(400);
	localparam logic [COORD_BITS-1:0] RST_CENTER_ROW = COORD_BITS'(300);
	localparam logic [STEP_W-1:0]     RST_PIXEL_STEP = STEP_W'(1491308);

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_MAX_ITER   = 2'd0,
		REG_CENTER_COL = 2'd1,
		REG_CENTER_ROW = 2'd2,
		REG_PIXEL_STEP = 2'd3
	} reg_idx_t;

	typedef logic signed [XW-1:0] coord_t;
	typedef logic signed [PW-1:0] wide_t;

	// Saturation bounds of a plane coordinate, sign-extended to the wide type.
	localparam wide_t SAT_HI = {{(PW-XW+1){1'b0}}, {(XW-1){1'b1}}};
	localparam wide_t SAT_LO = {{(PW-XW+1){1'b1}}, {(XW-1){1'b0}}};

	typedef struct packed {
		logic [MAX_ITER_W-1:0] max_iter;
		logic [COORD_BITS-1:0] center_col;
		logic [COORD_BITS-1:0] center_row;
		logic [STEP_W-1:0]     pixel_step;
	} cfg_t;

	// Point c as handed from the front end to the iteration engine.
	typedef struct packed {
		coord_t c_re;
		coord_t c_im;
	} point_t;

	// Outcome of one pixel's iteration.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               escaped;
	} iter_res_t;

	// Clamp a wide signed value into the Q4.F coordinate range.
	function automatic coord_t sat_coord(input wide_t v);
		coord_t r;
		if (v > SAT_HI) begin
			r = coord_t'(SAT_HI[XW-1:0]);
		end else if (v < SAT_LO) begin
			r = coord_t'(SAT_LO[XW-1:0]);
		end else begin
			r = coord_t'(v[XW-1:0]);
		end
		return r;
	endfunction

endpackage

/* design/met_front.sv */
// Front end: accepts pixels and maps each one to its point c on the plane.
// Depends on met_pkg; feeds met_fifo.
module met_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  met_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [met_pkg::COORD_BITS-1:0] pixel_col,
	input  logic [met_pkg::COORD_BITS-1:0] pixel_row,
	output logic                          wr_valid,
	output met_pkg::point_t               wr_data,
	input  logic                          wr_full
);
	import met_pkg::*;

	localparam int PRODW = COORD_BITS + 1 + STEP_W + 1;

	logic signed [COORD_BITS:0] dcol;
	logic signed [COORD_BITS:0] drow;
	logic signed [STEP_W:0]     step_s;
	logic signed [PRODW-1:0]    prod_re_d;
	logic signed [PRODW-1:0]    prod_im_d;
	logic signed [PRODW-1:0]    prod_re_s1;
	logic signed [PRODW-1:0]    prod_im_s1;
	logic                       valid_s1;

	// Pixel offsets from the center, scaled by the step.
	assign dcol      = $signed({1'b0, pixel_col}) - $signed({1'b0, cfg.center_col});
	assign drow      = $signed({1'b0, cfg.center_row}) - $signed({1'b0, pixel_row});
	assign step_s    = $signed({1'b0, cfg.pixel_step});
	assign prod_re_d = dcol * step_s;
	assign prod_im_d = drow * step_s;

	// The stage moves on whenever the queue can take its content.
	assign in_ready = !valid_s1 || !wr_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_re_s1 <= prod_re_d;
			prod_im_s1 <= prod_im_d;
		end
	end

	// Clamp c into the plane format on the way into the queue.
	assign wr_valid     = valid_s1;
	assign wr_data.c_re = sat_coord(wide_t'(prod_re_s1));
	assign wr_data.c_im = sat_coord(wide_t'(prod_im_s1));

endmodule

/* design/met_fifo.sv */
// Short queue of plane points between the front end and the iteration engine.
// Depends on met_pkg and the assertion macro header.
`include "mandelbrot_escape_time_pixel_defines.svh"

module met_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  met_pkg::point_t push_data,
	output logic            full,
	input  logic            pop,
	output met_pkg::point_t pop_data,
	output logic            empty
);
	import met_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	point_t          entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`MET_ASSERT_IMPLY(a_fifo_bound, 1'b1, count_q <= CW'(DEPTH), "queue level above depth")
	`MET_ASSERT_NEXT(a_fifo_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "queue level did not rise on a push")
	`MET_ASSERT_NEXT(a_fifo_down, do_pop && !do_push, count_q == $past(count_q) - 1'b1, "queue level did not fall on a pop")

endmodule

/* design/met_iter.sv */
// Back end: runs z = z^2 + c for one point at a time and reports the count.
// Depends on met_pkg and the assertion macro header; fed by met_fifo.
`include "mandelbrot_escape_time_pixel_defines.svh"

module met_iter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [met_pkg::MAX_ITER_W-1:0] max_iter,
	input  logic                          empty,
	input  met_pkg::point_t               pop_data,
	output logic                          pop,
	output logic                          res_valid,
	output met_pkg::iter_res_t            res,
	input  logic                          res_ready
);
	import met_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_CHK  = 4'b0100,
		ST_DONE = 4'b1000
	} it_state_t;

	it_state_t          state_q;
	coord_t             c_re_q;
	coord_t             c_im_q;
	coord_t             x_q;
	coord_t             y_q;
	wide_t              xx_q;
	wide_t              yy_q;
	wide_t              xy_q;
	logic [COUNT_W-1:0] n_q;
	logic               esc_q;
	logic [PW-1:0]      mag_sum;
	logic               hit;
	logic               last;
	wide_t              re_d;
	wide_t              im_d;

	// Escape test on the exact square sum of the current iterate.
	assign mag_sum = xx_q + yy_q;
	assign hit     = |mag_sum[PW-1:ESC_BIT];
	assign last    = (n_q == COUNT_W'(max_iter));

	// Next iterate: floored squares and doubled cross product, plus c.
	assign re_d = (xx_q >>> FRAC_BITS) - (yy_q >>> FRAC_BITS) + wide_t'(c_re_q);
	assign im_d = (xy_q >>> (FRAC_BITS - 1)) + wide_t'(c_im_q);

	assign pop       = (state_q == ST_IDLE) && !empty;
	assign res_valid = (state_q == ST_DONE);
	assign res.count   = n_q;
	assign res.escaped = esc_q;

	// Sequencer: each iteration passes through a multiply state and then a check state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (hit || last) state_q <= ST_DONE;
					else state_q <= ST_MUL;
				end
				ST_DONE: begin
					if (res_ready) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath. The first iterate from z = 0 is c itself.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				c_re_q <= pop_data.c_re;
				c_im_q <= pop_data.c_im;
				x_q    <= pop_data.c_re;
				y_q    <= pop_data.c_im;
				n_q    <= '0;
			end
			ST_MUL: begin
				xx_q <= wide_t'(x_q) * wide_t'(x_q);
				yy_q <= wide_t'(y_q) * wide_t'(y_q);
				xy_q <= wide_t'(x_q) * wide_t'(y_q);
			end
			ST_CHK: begin
				esc_q <= hit;
				if (!hit) begin
					n_q <= n_q + 1'b1;
					x_q <= sat_coord(re_d);
					y_q <= sat_coord(im_d);
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	`MET_ASSERT_NEXT(a_mul_then_chk, state_q == ST_MUL, state_q == ST_CHK, "multiply cycle not followed by check")
	`MET_ASSERT_NEXT(a_done_holds, state_q == ST_DONE && !res_ready, state_q == ST_DONE && $stable(n_q) && $stable(esc_q), "result changed while stalled")
	`MET_ASSERT_NEXT(a_start_clean, state_q == ST_IDLE && !empty, state_q == ST_MUL && n_q == '0, "new point did not start at count zero")

endmodule

/* design/met_color.sv */
// Color stage: turns the iteration count into RGB bytes and holds the result.
// Depends on met_pkg; fed by met_iter.
module met_color (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  met_pkg::iter_res_t          in_res,
	output logic                        in_ready,
	output logic                        out_valid,
	output met_pkg::iter_res_t          out_res,
	output logic [met_pkg::COLOR_W-1:0] red,
	output logic [met_pkg::COLOR_W-1:0] green,
	output logic [met_pkg::COLOR_W-1:0] blue,
	input  logic                        out_ready
);
	import met_pkg::*;

	// Channel level = base + slope * n; byte = min(255, 255 * level / 1000).
	localparam int NCH         = 3;
	localparam int LVL_W       = 14;
	localparam int SC_W        = 18;
	localparam int COLOR_DIV   = 1000;
	localparam int COLOR_GAIN  = 255;
	localparam int RECIP_SHIFT = 28;
	localparam int COLOR_RECIP = ((1 << RECIP_SHIFT) + COLOR_DIV - 1) / COLOR_DIV;
	localparam int RC_W        = $clog2(COLOR_RECIP + 1);
	localparam logic [NCH-1:0][LVL_W-1:0] BASES  = {LVL_W'(300), LVL_W'(200), LVL_W'(100)};
	localparam logic [NCH-1:0][LVL_W-1:0] SLOPES = {LVL_W'(3), LVL_W'(9), LVL_W'(6)};

	logic [NCH-1:0][LVL_W-1:0]   level_d;
	logic [NCH-1:0]              sat_d;
	logic [NCH-1:0][SC_W-1:0]    scaled_d;
	logic [NCH-1:0]              sat_s1;
	logic [NCH-1:0][SC_W-1:0]    scaled_s1;
	iter_res_t                   res_s1;
	logic                        valid_s1;
	logic [NCH-1:0][SC_W+RC_W-1:0] quot_d;
	logic [NCH-1:0][COLOR_W-1:0] byte_d;
	logic [NCH-1:0][COLOR_W-1:0] color_q;
	iter_res_t                   res_q;
	logic                        valid_q;
	logic                        adv;

	// First stage: channel levels, the clamp decision and the gain product.
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			level_d[ch]  = BASES[ch] + SLOPES[ch] * LVL_W'(in_res.count);
			sat_d[ch]    = (level_d[ch] >= LVL_W'(COLOR_DIV));
			scaled_d[ch] = SC_W'(level_d[ch]) * SC_W'(COLOR_GAIN);
		end
	end

	// Second stage: divide by 1000 through a reciprocal multiply.
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			quot_d[ch] = (SC_W+RC_W)'(scaled_s1[ch]) * (SC_W+RC_W)'(COLOR_RECIP);
			byte_d[ch] = sat_s1[ch] ? {COLOR_W{1'b1}} : quot_d[ch][RECIP_SHIFT +: COLOR_W];
		end
	end

	assign adv      = !valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv) valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sat_s1    <= sat_d;
			scaled_s1 <= scaled_d;
			res_s1    <= in_res;
		end
		if (adv && valid_s1) begin
			color_q <= byte_d;
			res_q   <= res_s1;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign red       = color_q[0];
	assign green     = color_q[1];
	assign blue      = color_q[2];

endmodule

/* design/mandelbrot_escape_time_pixel.sv */
// Top level of the Mandelbrot escape-time pixel engine: register port and stream ports.
// Depends on met_pkg, met_front, met_fifo, met_iter and met_color.
// Each pixel (column, row) is mapped to c = ((col - center_col) * step,
// (center_row - row) * step) in signed Q4.28 and iterated as z = z^2 + c from zero
// until |z|^2 >= 4 or the limit max_iter + 1 is reached; the count, an escape flag
// and three color bytes come back as one transaction per pixel, in order. A pixel
// that runs k iterations (k = n + 1 when it escapes, max_iter + 1 when it does not)
// holds the iteration engine for all k of them, each iteration passing through the
// three 32x32 multipliers and then through the escape check and update; the engine
// takes no new point until its result is accepted, and the reset limit is 500. The
// front end keeps taking pixels until its queue (QUEUE_DEPTH entries plus one stage)
// is full, and the color stage registers each result in its first and second stage.
module mandelbrot_escape_time_pixel #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Pixel input: tdata = pixel_col [11:0], pixel_row [23:12].
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,
	// Result: tdata = iter_count [10:0], red [18:11], green [26:19], blue [34:27],
	// zero [39:35]; tuser = escaped [0].
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser
);
	import met_pkg::*;

	cfg_t                cfg_q;
	reg_idx_t            reg_sel;
	logic                reg_wr;
	logic                wr_valid;
	point_t              wr_data;
	logic                q_full;
	logic                q_empty;
	logic                q_pop;
	point_t              q_data;
	logic                res_valid;
	iter_res_t           res;
	logic                res_ready;
	iter_res_t           out_res;
	logic [COLOR_W-1:0]  red;
	logic [COLOR_W-1:0]  green;
	logic [COLOR_W-1:0]  blue;

	// Register file: a write lands on the access cycle of a transaction.
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_iter   <= RST_MAX_ITER;
			cfg_q.center_col <= RST_CENTER_COL;
			cfg_q.center_row <= RST_CENTER_ROW;
			cfg_q.pixel_step <= RST_PIXEL_STEP;
		end else if (reg_wr) begin
			unique case (reg_sel)
				REG_MAX_ITER:   cfg_q.max_iter   <= pwdata[MAX_ITER_W-1:0];
				REG_CENTER_COL: cfg_q.center_col <= pwdata[COORD_BITS-1:0];
				REG_CENTER_ROW: cfg_q.center_row <= pwdata[COORD_BITS-1:0];
				REG_PIXEL_STEP: cfg_q.pixel_step <= pwdata[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read-back of the selected register.
	always_comb begin
		unique case (reg_sel)
			REG_MAX_ITER:   prdata = 32'(cfg_q.max_iter);
			REG_CENTER_COL: prdata = 32'(cfg_q.center_col);
			REG_CENTER_ROW: prdata = 32'(cfg_q.center_row);
			REG_PIXEL_STEP: prdata = 32'(cfg_q.pixel_step);
			default:        prdata = '0;
		endcase
	end

	met_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.pixel_col (s_axis_tdata[COORD_BITS-1:0]),
		.pixel_row (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.wr_valid  (wr_valid),
		.wr_data   (wr_data),
		.wr_full   (q_full)
	);

	met_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (wr_valid),
		.push_data (wr_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	met_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_iter  (cfg_q.max_iter),
		.empty     (q_empty),
		.pop_data  (q_data),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	met_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.in_ready  (res_ready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_ready (m_axis_tready)
	);

	// Result packing.
	assign m_axis_tdata = {5'b0, blue, green, red, out_res.count};
	assign m_axis_tuser = out_res.escaped;

endmodule
